FILE: src/thermistor_temperature_from_sum_unit_macros.svh
// Assertion macros for the controller of the thermistor temperature unit.
`ifndef THERMISTOR_TEMPERATURE_FROM_SUM_UNIT_MACROS_SVH
`define THERMISTOR_TEMPERATURE_FROM_SUM_UNIT_MACROS_SVH
// Check that a condition holds in the same cycle as its trigger.
`define TFS_ASSERT_SAME(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("tfs assertion failed");
// Check that a condition holds in the cycle after its trigger.
`define TFS_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("tfs assertion failed");
`endif

FILE: src/tfs_pkg.sv
// Package: constants and controller/datapath interface types for the unit.
package tfs_pkg;
    localparam int LOG_READINGS_DEF = 7;
    localparam int BETA_W = 14;
    localparam logic [BETA_W-1:0] BETA_RESET = 14'd3950;
    localparam logic [63:0] RATIO_LOW = 64'd357913942;
    localparam logic [63:0] RATIO_HIGH = 64'd1789569706;
    localparam logic [30:0] RATIO_ONE = 31'd1073741824;
    localparam logic [40:0] INV_T0_SCALED = 41'd7202695;
    localparam logic [53:0] KELVIN_OFFSET_MILLI = 54'd273150;
    localparam logic [63:0] T_DIVIDEND = 64'd1000 << 31;
    localparam logic [79:0] RATIO_DIVISOR = 80'd3125;
    // Fraction bits of the reciprocal that scales the sum to the ratio
    localparam int RECIP_SHIFT = 39;

    // Divider operand selections
    localparam logic [1:0] DIV_Q1 = 2'd0;
    localparam logic [1:0] DIV_Q = 2'd1;
    localparam logic [1:0] DIV_T = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_lo;
        logic       mul_hi;
        logic       div_start;
        logic [1:0] div_sel;
        logic       sqrt_start;
        logic       cap_ratio;
        logic       cap_q1;
        logic       cap_q;
        logic       cap_t;
        logic       set_fail;
        logic       out_load;
    } tfs_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic sqrt_done;
        logic in_win;
        logic d_zero;
    } tfs_sts_t;
endpackage

FILE: src/thermistor_temperature_from_sum_unit.sv
// Top level of the beta-thermistor temperature unit.
// Converts a batch sum of resistance readings (0.1 ohm units) into a temperature in
// milli-degrees C. One item is in work at a time: an in-range item passes a reciprocal
// multiply of the sum in low and high halves, a 16-step square root and three 64-step
// divisions on the shared one-bit-per-cycle divider before its result reaches the output
// register; an out-of-range item goes there straight from the range check, and an item
// with a zero final divisor skips the last division. The next item is accepted as soon
// as the previous result sits in the output register; while an unread result waits
// there, a finished item holds and the input stalls.
module thermistor_temperature_from_sum_unit
    import tfs_pkg::*;
#(
    parameter int LOG_READINGS = LOG_READINGS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [26:0] sum_readings
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] milli_degrees_c
    output logic [0:0]        m_tuser,   // [0] out_of_range
    input  logic              cfg_we,
    input  logic [BETA_W-1:0] cfg_wdata
);
    tfs_cmd_t cmd;
    tfs_sts_t sts;
    logic     oor;

    tfs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tfs_dp #(.LOG_READINGS(LOG_READINGS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .sum_in    (s_tdata[26:0]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .temp_out  (m_tdata),
        .oor_out   (oor)
    );

    assign m_tuser = oor;
endmodule

FILE: src/tfs_div.sv
// Shared restoring divider: 64-bit dividend, 40-bit divisor, one bit per cycle.
module tfs_div
    import tfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [39:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);
    logic [40:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [39:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [40:0] rem_sh;

    // One shift-and-subtract step
    always_comb
    begin
        rem_sh = {rem_reg[39:0], quo_reg[63]};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: src/tfs_sqrt.sv
// Floor integer square root of a 32-bit value, one result bit per cycle, 16 steps.
module tfs_sqrt
    import tfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] value,
    output logic        done,
    output logic [15:0] root
);
    logic [31:0] v_reg, v_next;
    logic [31:0] res_reg, res_next;
    logic [31:0] bit_reg, bit_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // Advance one bit pair of the root
    always_comb
    begin
        trial = {1'b0, res_reg} + {1'b0, bit_reg};
        v_next = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next = value;
            res_next = '0;
            bit_next = 32'h4000_0000;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next = v_reg - trial[31:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[15:0];
endmodule

FILE: src/tfs_dp.sv
// Datapath: operand registers, shared divider, square root and result register.
module tfs_dp
    import tfs_pkg::*;
#(
    parameter int LOG_READINGS = LOG_READINGS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tfs_cmd_t          cmd,
    output tfs_sts_t          sts,
    input  logic [26:0]       sum_in,
    input  logic              cfg_we,
    input  logic [BETA_W-1:0] cfg_wdata,
    output logic [31:0]       temp_out,
    output logic              oor_out
);
    localparam int SHIFT = 25 - LOG_READINGS;
    // Rounded-up reciprocal of the ratio divisor; exact floor for any 27-bit sum
    localparam logic [79:0] RECIP_FULL =
        ((80'd1 << (RECIP_SHIFT + SHIFT)) + RATIO_DIVISOR - 80'd1) / RATIO_DIVISOR;
    localparam logic [53:0] RECIP = RECIP_FULL[53:0];

    logic [BETA_W-1:0] beta_reg;
    logic [26:0]       sum_reg;
    logic [53:0]       prod_lo_reg;
    logic [53:0]       prod_hi_reg;
    logic [30:0]       ratio_reg;
    logic              win_reg;
    logic [63:0]       q1_reg;
    logic              neg_reg;
    logic [40:0]       d_reg;
    logic [53:0]       t_reg;
    logic              fail_reg;
    logic [31:0]       temp_reg;
    logic              oor_reg;

    logic [63:0] div_a;
    logic [39:0] div_b;
    logic [63:0] quo;
    logic        div_busy, div_done;
    logic        sqrt_done;
    logic [15:0] root;

    logic [26:0] mul_b;
    logic [53:0] mul_p;
    logic [80:0] prod_full;
    logic [41:0] ratio_wide;
    logic        r_neg;
    logic [30:0] diff;
    logic [33:0] num_mag;
    logic [33:0] den;
    logic [39:0] q_s;
    logic        d_neg;
    logic [40:0] d_abs;
    logic [53:0] t_s;
    logic [31:0] t_sat;

    // Ratio by reciprocal multiply, one half of the reciprocal per cycle
    always_comb
    begin
        mul_b = cmd.mul_hi ? RECIP[53:27] : RECIP[26:0];
        mul_p = {27'd0, sum_reg} * {27'd0, mul_b};
        prod_full = {prod_hi_reg, 27'd0} + {27'd0, prod_lo_reg};
        ratio_wide = prod_full[RECIP_SHIFT +: 42];
    end

    // Numerator and denominator of the log approximation
    always_comb
    begin
        r_neg = ratio_reg < RATIO_ONE;
        diff = r_neg ? (RATIO_ONE - ratio_reg) : (ratio_reg - RATIO_ONE);
        num_mag = {1'b0, diff, 2'b00} + {2'b00, diff, 1'b0};
        den = {3'b000, ratio_reg} + {3'b000, RATIO_ONE} + {1'b0, root, 17'd0};
        d_neg = d_reg[40];
        d_abs = d_neg ? (41'd0 - d_reg) : d_reg;
    end

    // Select divider operands
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_Q1:
            begin
                div_a = {num_mag[32:0], 31'd0};
                div_b = {{(40-BETA_W){1'b0}}, beta_reg};
            end
            DIV_Q:
            begin
                div_a = q1_reg;
                div_b = {6'd0, den};
            end
            default:
            begin
                div_a = T_DIVIDEND;
                div_b = d_abs[39:0];
            end
        endcase
    end

    tfs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    tfs_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .value ({1'b0, ratio_reg}),
        .done  (sqrt_done),
        .root  (root)
    );

    // Signed quotient, final temperature and saturation
    always_comb
    begin
        q_s = neg_reg ? (40'd0 - {1'b0, quo[38:0]}) : {1'b0, quo[38:0]};
        t_s = (d_neg ? (54'd0 - {2'b00, quo[51:0]}) : {2'b00, quo[51:0]})
            - KELVIN_OFFSET_MILLI;
        if ($signed(t_reg) > $signed(54'sh7FFF_FFFF))
            t_sat = 32'h7FFF_FFFF;
        else if ($signed(t_reg) < -$signed(54'sh8000_0000))
            t_sat = 32'h8000_0000;
        else
            t_sat = t_reg[31:0];
    end

    // Hold the beta register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beta_reg <= BETA_RESET;
        else if (cfg_we)
            beta_reg <= cfg_wdata;
    end

    // Capture intermediate values on controller command
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sum_reg <= sum_in;
            fail_reg <= 1'b0;
        end
        if (cmd.mul_lo)
            prod_lo_reg <= mul_p;
        if (cmd.mul_hi)
            prod_hi_reg <= mul_p;
        if (cmd.cap_ratio)
        begin
            ratio_reg <= ratio_wide[30:0];
            win_reg <= ({22'd0, ratio_wide} >= RATIO_LOW)
                && ({22'd0, ratio_wide} <= RATIO_HIGH) && (beta_reg != '0);
        end
        if (cmd.cap_q1)
        begin
            q1_reg <= quo;
            neg_reg <= r_neg;
        end
        if (cmd.cap_q)
            d_reg <= INV_T0_SCALED + {q_s[39], q_s};
        if (cmd.cap_t)
            t_reg <= t_s;
        if (cmd.set_fail)
            fail_reg <= 1'b1;
        if (cmd.out_load)
        begin
            temp_reg <= fail_reg ? 32'd0 : t_sat;
            oor_reg <= fail_reg;
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign sts.sqrt_done = sqrt_done;
    assign sts.in_win = win_reg;
    assign sts.d_zero = (d_reg == '0);
    assign temp_out = temp_reg;
    assign oor_out = oor_reg;
endmodule

FILE: src/tfs_ctrl.sv
// Controller: sequences the conversion steps and owns the output handshake.
module tfs_ctrl
    import tfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  tfs_sts_t sts,
    output tfs_cmd_t cmd
);
    `include "thermistor_temperature_from_sum_unit_macros.svh"

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RATIO = 4'd1;
    localparam logic [3:0] S_RMUL  = 4'd2;
    localparam logic [3:0] S_RCAP  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_Q1    = 4'd6;
    localparam logic [3:0] S_QS    = 4'd7;
    localparam logic [3:0] S_Q     = 4'd8;
    localparam logic [3:0] S_D     = 4'd9;
    localparam logic [3:0] S_T     = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    // Next state and commands
    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_RATIO;
                end
            S_RATIO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_RMUL;
            end
            S_RMUL:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_RCAP;
            end
            S_RCAP:
            begin
                cmd.cap_ratio = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
                if (!sts.in_win)
                begin
                    cmd.set_fail = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            S_SQRT:
            begin
                cmd.div_sel = DIV_Q1;
                if (sts.sqrt_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_Q1;
                end
            end
            S_Q1:
            begin
                cmd.div_sel = DIV_Q1;
                if (sts.div_done)
                begin
                    cmd.cap_q1 = 1'b1;
                    state_next = S_QS;
                end
            end
            S_QS:
            begin
                cmd.div_sel = DIV_Q;
                cmd.div_start = 1'b1;
                state_next = S_Q;
            end
            S_Q:
            begin
                cmd.div_sel = DIV_Q;
                if (sts.div_done)
                begin
                    cmd.cap_q = 1'b1;
                    state_next = S_D;
                end
            end
            S_D:
            begin
                cmd.div_sel = DIV_T;
                if (sts.d_zero)
                begin
                    cmd.set_fail = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_T;
                end
            end
            S_T:
            begin
                cmd.div_sel = DIV_T;
                if (sts.div_done)
                begin
                    cmd.cap_t = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.out_load)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    `TFS_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == S_RATIO)
    `TFS_ASSERT_SAME(a_no_overwrite, cmd.out_load, !ov_reg || out_ready)
    `TFS_ASSERT_SAME(a_div_free, cmd.div_start, !sts.div_busy)
endmodule

FILE: sim/tb_top.sv
// Testbench for the thermistor temperature unit: random and directed sums, scoreboard check.
`timescale 1ns / 1ps

module tb_top;
    import tfs_pkg::*;

    localparam int unsigned SUM_MAX   = 127999872;
    localparam int unsigned WIN_LO    = 4266667;
    localparam int unsigned WIN_HI    = 21333333;
    localparam int unsigned LIMIT     = 3000000;
    localparam int unsigned DRAIN     = 400;
    localparam int unsigned HOLD_LEN  = 3000;

    // Temperature predictor and store of pending temperatures
    class temp_scoreboard;
        logic [31:0] temp_q[$];
        bit          flag_q[$];
        int          errors;
        int          checked;
        int          flagged;

        function automatic int unsigned root_floor(int unsigned v);
            int unsigned acc;
            int unsigned bitv;
            acc  = 0;
            bitv = 32'h4000_0000;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= acc + bitv)
                begin
                    v   = v - (acc + bitv);
                    acc = (acc >> 1) + bitv;
                end
                else
                    acc = acc >> 1;
                bitv = bitv >> 2;
            end
            return acc;
        endfunction

        // Compute the temperature for one accepted sum
        function void note_sum(logic [26:0] sum, logic [BETA_W-1:0] beta);
            longint ratio;
            longint num;
            longint den;
            longint q;
            longint d;
            longint t;
            logic [31:0] res;
            bit fail;
            ratio = (longint'(sum) << 18) / 64'sd3125;
            res   = '0;
            fail  = 1'b1;
            if (ratio >= 64'sd357913942 && ratio <= 64'sd1789569706 && beta != 0)
            begin
                num = 64'sd6 * (ratio - 64'sd1073741824);
                den = ratio + 64'sd1073741824
                    + longint'(root_floor(int'(ratio))) * 64'sd131072;
                q = (num * 64'sd2147483648) / longint'({50'b0, beta});
                q = q / den;
                d = 64'sd7202695 + q;
                if (d != 0)
                begin
                    t = (64'sd1000 * 64'sd2147483648) / d - 64'sd273150;
                    if (t > 64'sd2147483647)
                        t = 64'sd2147483647;
                    if (t < -64'sd2147483648)
                        t = -64'sd2147483648;
                    res  = t[31:0];
                    fail = 1'b0;
                end
            end
            temp_q.push_back(res);
            flag_q.push_back(fail);
        endfunction

        // Compare one result with the oldest pending temperature
        function void check_result(logic [31:0] data, logic flag);
            logic [31:0] exp_t;
            bit exp_f;
            if (temp_q.size() == 0)
            begin
                $display("%0t: unexpected result temp=%0d flag=%0b", $time, $signed(data), flag);
                errors++;
                return;
            end
            exp_t = temp_q.pop_front();
            exp_f = flag_q.pop_front();
            checked++;
            if (exp_f)
                flagged++;
            if (data !== exp_t)
            begin
                $display("%0t: temp mismatch expected %0d actual %0d",
                         $time, $signed(exp_t), $signed(data));
                errors++;
            end
            if (flag !== exp_f)
            begin
                $display("%0t: out_of_range mismatch expected %0b actual %0b",
                         $time, exp_f, flag);
                errors++;
            end
        endfunction

        function int pending();
            return temp_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic [0:0]        m_tuser;
    logic              cfg_we;
    logic [BETA_W-1:0] cfg_wdata;

    temp_scoreboard    sb;
    logic [BETA_W-1:0] beta_now;
    bit                quiet;
    bit                hold_req;
    int unsigned       hold_cnt;
    int unsigned       cycles;
    int                sent;

    thermistor_temperature_from_sum_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receive side: check items, stall at random, hold off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0]);
            if (hold_req && hold_cnt == 0)
            begin
                hold_cnt <= HOLD_LEN;
                m_tready <= 1'b0;
            end
            else if (hold_cnt > 1)
            begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                hold_cnt <= 0;
                m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // Offer one item and wait for its acceptance
    task automatic send_sum(logic [26:0] sum);
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, sum};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sum(sum, beta_now);
        sent++;
    endtask

    // Drain the unit, then write beta
    task automatic set_beta(logic [BETA_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        beta_now = value;
    endtask

    function automatic logic [26:0] rand_sum();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            return 27'($urandom_range(WIN_HI, WIN_LO));
        else if (pick < 88)
            return 27'($urandom_range(SUM_MAX, 0));
        else if (pick < 94)
            return 27'($urandom_range(WIN_LO + 40, WIN_LO - 40));
        else
            return 27'($urandom_range(WIN_HI + 40, WIN_HI - 40));
    endfunction

    // Directed sums: extremes, window edges, nominal 10 kilohm
    task automatic run_directed();
        logic [26:0] pts[12];
        pts = '{27'd0, 27'd1, 27'(WIN_LO - 1), 27'(WIN_LO), 27'(WIN_LO + 1), 27'd12800000,
                27'(WIN_HI - 1), 27'(WIN_HI), 27'(WIN_HI + 1), 27'd67108864, 27'(SUM_MAX),
                27'h2AAAAAA};
        foreach (pts[i])
            send_sum(pts[i]);
    endtask

    initial
    begin
        logic [BETA_W-1:0] betas[7];
        int per_phase;
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        cycles    = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        sent      = 0;
        beta_now  = BETA_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        betas = '{BETA_RESET, 14'd1000, 14'd10000, 14'd0, 14'd1, 14'h3FFF, 14'd5000};
        per_phase = 265;
        foreach (betas[p])
        begin
            if (p != 0)
                set_beta(p == 6 ? 14'($urandom_range(10000, 1000)) : betas[p]);
            run_directed();
            for (int i = 0; i < per_phase; i++)
            begin
                // Quiet stretch with no idling on either side
                quiet = (p == 1 && i >= 50 && i < 250);
                // Long hold-off on the receive side while items keep coming
                hold_req = (p == 2 && i == 20);
                send_sum(rand_sum());
            end
            quiet    = 1'b0;
            hold_req = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        $display("Sent %0d sums over %0d beta settings, %0d results checked",
                 sent, 7, sb.checked);
        $display("%0d results flagged out of range, %0d errors", sb.flagged, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: thermistor_temperature_from_sum_unit.f
+incdir+src
src/tfs_pkg.sv
src/tfs_div.sv
src/tfs_sqrt.sv
src/tfs_dp.sv
src/tfs_ctrl.sv
src/thermistor_temperature_from_sum_unit.sv
sim/tb_top.sv
